### design/smm_pkg.sv
`default_nettype none

package smm_pkg;

   localparam int SensorCount = 4;
   localparam int LineCapacity = 16;
   localparam int HeadDepth = 4;
   localparam int QueueDepth = 2;

   localparam int ValueWidth = 12;
   localparam int IndexWidth = 2;
   localparam int ByteWidth = 8;
   localparam int LenWidth = $clog2(LineCapacity + 1);
   localparam int HeadIdxWidth = $clog2(HeadDepth);
   localparam int QPtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCountWidth = $clog2(QueueDepth + 1);

   localparam logic signed [ValueWidth-1:0] MinReset = 12'sd999;
   localparam logic signed [ValueWidth-1:0] MaxReset = -12'sd999;

   localparam logic [ByteWidth-1:0] CharCr = 8'h0d;
   localparam logic [ByteWidth-1:0] CharLf = 8'h0a;
   localparam logic [ByteWidth-1:0] CharA = 8'h41;
   localparam logic [ByteWidth-1:0] CharT = 8'h54;
   localparam logic [ByteWidth-1:0] CharSpace = 8'h20;
   localparam logic [ByteWidth-1:0] CharR = 8'h52;
   localparam logic [ByteWidth-1:0] CharOne = 8'h31;
   localparam logic [ByteWidth-1:0] CharTwo = 8'h32;
   localparam logic [ByteWidth-1:0] CharThree = 8'h33;
   localparam logic [ByteWidth-1:0] CharFour = 8'h34;

   typedef enum logic [2:0] {
      REPLY_OK      = 3'd0,
      REPLY_CURRENT = 3'd1,
      REPLY_MIN     = 3'd2,
      REPLY_MAX     = 3'd3,
      REPLY_ACTIVE  = 3'd4
   } reply_kind_type;

   typedef enum logic [1:0] {
      OP_SENSOR = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_REPLY  = 2'd2
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic [IndexWidth-1:0] index;
      logic present;
      logic signed [ValueWidth-1:0] reading;
      reply_kind_type kind;
   } op_type;

endpackage

`default_nettype wire

### design/sensor_minmax_at_command_monitor_top.sv
// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  command, sensor index/present/reading, rx byte
// rsp_      out        rsp_valid/rsp_ready  reply kind and four sensor values
//
// The block takes one beat per cycle while the queue is not full; a reply passes through the
// operation queue and then the reply register before it is valid.
// The execute stage that drains the two-entry operation queue sets the rate.
// Reset clears the line buffer, the queue, the reply valid flag and all sensor statistics.
// A held reply stalls a reply at the queue head and everything behind it;
// req_ready drops when the queue is full.
`default_nettype none

module sensor_minmax_at_command_monitor_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [smm_pkg::IndexWidth-1:0] req_sensor_index,
   input  logic req_sensor_present,
   input  logic signed [smm_pkg::ValueWidth-1:0] req_reading,
   input  logic [smm_pkg::ByteWidth-1:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_reply_kind,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_0,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_1,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_2,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_3
);
   import smm_pkg::*;

   logic queue_full;
   logic queue_empty;
   logic push;
   logic pop;
   op_type push_op;
   op_type head_op;

   smm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_sensor_index   (req_sensor_index),
      .req_sensor_present (req_sensor_present),
      .req_reading        (req_reading),
      .req_rx_byte        (req_rx_byte),
      .queue_full         (queue_full),
      .push               (push),
      .push_op            (push_op)
   );

   smm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   smm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (queue_empty),
      .head_op        (head_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_value_0    (rsp_value_0),
      .rsp_value_1    (rsp_value_1),
      .rsp_value_2    (rsp_value_2),
      .rsp_value_3    (rsp_value_3)
   );

endmodule

`default_nettype wire

### design/smm_front.sv
`default_nettype none

module smm_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [smm_pkg::IndexWidth-1:0] req_sensor_index,
   input  logic req_sensor_present,
   input  logic signed [smm_pkg::ValueWidth-1:0] req_reading,
   input  logic [smm_pkg::ByteWidth-1:0] req_rx_byte,
   input  logic queue_full,
   output logic push,
   output smm_pkg::op_type push_op
);
   import smm_pkg::*;

   logic [LenWidth-1:0] len_ff, len_in;
   logic [ByteWidth-1:0] head_ff [HeadDepth];
   logic [ByteWidth-1:0] head_in [HeadDepth];
   logic accept;
   logic is_term;
   logic is_at;
   logic match;
   op_type op;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign is_term = (req_rx_byte == CharCr) || (req_rx_byte == CharLf);
   assign is_at = (head_ff[0] == CharA) && (head_ff[1] == CharT);

   always_comb begin
      op.code = OP_SENSOR;
      op.index = req_sensor_index;
      op.present = req_sensor_present;
      op.reading = req_reading;
      op.kind = REPLY_OK;
      match = 1'b0;
      if (req_command) begin
         if (is_at && len_ff == LenWidth'(2)) begin
            match = 1'b1;
            op.code = OP_REPLY;
            op.kind = REPLY_OK;
         end else if (is_at && len_ff == LenWidth'(4) && head_ff[2] == CharSpace) begin
            match = 1'b1;
            op.code = OP_REPLY;
            case (head_ff[3])
               CharR: begin
                  op.code = OP_CLEAR;
               end
               CharOne: begin
                  op.kind = REPLY_CURRENT;
               end
               CharTwo: begin
                  op.kind = REPLY_MIN;
               end
               CharThree: begin
                  op.kind = REPLY_MAX;
               end
               CharFour: begin
                  op.kind = REPLY_ACTIVE;
               end
               default: begin
                  match = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      len_in = len_ff;
      head_in = head_ff;
      push = 1'b0;
      push_op = op;
      if (accept) begin
         if (!req_command) begin
            push = 1'b1;
         end else if (is_term) begin
            push = match;
            len_in = '0;
         end else if (len_ff >= LenWidth'(LineCapacity)) begin
            head_in[0] = req_rx_byte;
            len_in = LenWidth'(1);
         end else begin
            if (len_ff < LenWidth'(HeadDepth)) begin
               head_in[len_ff[HeadIdxWidth-1:0]] = req_rx_byte;
            end
            len_in = len_ff + LenWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int k = 0; k < HeadDepth; k++) begin
            head_ff[k] <= '0;
         end
      end else begin
         len_ff <= len_in;
         head_ff <= head_in;
      end
   end

endmodule

`default_nettype wire

### design/smm_queue.sv
`default_nettype none

module smm_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  smm_pkg::op_type push_op,
   output logic full,
   input  logic pop,
   output logic empty,
   output smm_pkg::op_type head_op
);
   import smm_pkg::*;

   op_type entry_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCountWidth-1:0] count_ff, count_in;

   function automatic logic [QPtrWidth-1:0] next_ptr(input logic [QPtrWidth-1:0] ptr);
      logic [QPtrWidth-1:0] result;
      if (ptr == QPtrWidth'(QueueDepth - 1)) begin
         result = '0;
      end else begin
         result = ptr + QPtrWidth'(1);
      end
      return result;
   endfunction

   assign full = (count_ff == QCountWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

### design/smm_back.sv
`default_nettype none

module smm_back (
   input  logic clock,
   input  logic reset,
   input  logic empty,
   input  smm_pkg::op_type head_op,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_reply_kind,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_0,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_1,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_2,
   output logic signed [smm_pkg::ValueWidth-1:0] rsp_value_3
);
   import smm_pkg::*;

   logic signed [ValueWidth-1:0] cur_ff [SensorCount];
   logic signed [ValueWidth-1:0] cur_in [SensorCount];
   logic signed [ValueWidth-1:0] min_ff [SensorCount];
   logic signed [ValueWidth-1:0] min_in [SensorCount];
   logic signed [ValueWidth-1:0] max_ff [SensorCount];
   logic signed [ValueWidth-1:0] max_in [SensorCount];
   logic act_ff [SensorCount];
   logic act_in [SensorCount];
   logic rsp_valid_ff, rsp_valid_in;
   reply_kind_type kind_ff, kind_in;
   logic signed [ValueWidth-1:0] value_ff [4];
   logic signed [ValueWidth-1:0] value_in [4];
   logic out_free;
   logic load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop = !empty && ((head_op.code != OP_REPLY) || out_free);
   assign load = pop && (head_op.code == OP_REPLY);

   always_comb begin
      cur_in = cur_ff;
      min_in = min_ff;
      max_in = max_ff;
      act_in = act_ff;
      if (pop) begin
         case (head_op.code)
            OP_SENSOR: begin
               for (int k = 0; k < SensorCount; k++) begin
                  if (32'(head_op.index) == k) begin
                     act_in[k] = head_op.present;
                     if (head_op.present) begin
                        cur_in[k] = head_op.reading;
                        if (head_op.reading > max_ff[k]) begin
                           max_in[k] = head_op.reading;
                        end
                        if (head_op.reading < min_ff[k]) begin
                           min_in[k] = head_op.reading;
                        end
                     end
                  end
               end
            end
            OP_CLEAR: begin
               for (int k = 0; k < SensorCount; k++) begin
                  min_in[k] = MinReset;
                  max_in[k] = MaxReset;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in = kind_ff;
      value_in = value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         kind_in = head_op.kind;
         for (int k = 0; k < 4; k++) begin
            value_in[k] = '0;
            if (k < SensorCount) begin
               case (head_op.kind)
                  REPLY_CURRENT: value_in[k] = cur_ff[k];
                  REPLY_MIN:     value_in[k] = min_ff[k];
                  REPLY_MAX:     value_in[k] = max_ff[k];
                  REPLY_ACTIVE:  value_in[k] = {{(ValueWidth-1){1'b0}}, act_ff[k]};
                  default:       value_in[k] = '0;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SensorCount; k++) begin
            cur_ff[k] <= '0;
            min_ff[k] <= MinReset;
            max_ff[k] <= MaxReset;
            act_ff[k] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_ff <= cur_in;
         min_ff <= min_in;
         max_ff <= max_in;
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      value_ff <= value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_reply_kind = kind_ff;
   assign rsp_value_0 = value_ff[0];
   assign rsp_value_1 = value_ff[1];
   assign rsp_value_2 = value_ff[2];
   assign rsp_value_3 = value_ff[3];

endmodule

`default_nettype wire

### design/smm_checker.sv
`default_nettype none

module smm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_reply_kind,
   input logic signed [smm_pkg::ValueWidth-1:0] rsp_value_0,
   input logic signed [smm_pkg::ValueWidth-1:0] rsp_value_1,
   input logic signed [smm_pkg::ValueWidth-1:0] rsp_value_2,
   input logic signed [smm_pkg::ValueWidth-1:0] rsp_value_3
);
   import smm_pkg::*;

   a_reset_clears_reply: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Reply valid right after reset.");

   a_held_reply_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_kind) && $stable(rsp_value_0))
      else $error("Stalled reply beat changed.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reply_kind <= REPLY_ACTIVE))
      else $error("Reply kind out of range.");

   a_ok_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == REPLY_OK |->
         rsp_value_0 == '0 && rsp_value_1 == '0 && rsp_value_2 == '0 && rsp_value_3 == '0)
      else $error("OK reply carries nonzero values.");

   a_active_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == REPLY_ACTIVE |->
         (rsp_value_0 == 12'sd0 || rsp_value_0 == 12'sd1) &&
         (rsp_value_1 == 12'sd0 || rsp_value_1 == 12'sd1) &&
         (rsp_value_2 == 12'sd0 || rsp_value_2 == 12'sd1) &&
         (rsp_value_3 == 12'sd0 || rsp_value_3 == 12'sd1))
      else $error("Active reply carries a value other than a flag.");

endmodule

bind sensor_minmax_at_command_monitor_top smm_checker u_smm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_reply_kind (rsp_reply_kind),
   .rsp_value_0    (rsp_value_0),
   .rsp_value_1    (rsp_value_1),
   .rsp_value_2    (rsp_value_2),
   .rsp_value_3    (rsp_value_3)
);

`default_nettype wire

### test/tb_sensor_minmax_at_command_monitor_top.sv
module tb_sensor_minmax_at_command_monitor_top;
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0][ValueWidth-1:0] vals;
   } reply_beat_type;

   class reply_board;
      logic signed [ValueWidth-1:0] current_temp[SensorCount];
      logic signed [ValueWidth-1:0] lowest_temp[SensorCount];
      logic signed [ValueWidth-1:0] highest_temp[SensorCount];
      logic live[SensorCount];
      int unsigned chars_held;
      logic [ByteWidth-1:0] first_chars[HeadDepth];
      reply_beat_type expected_replies[$];
      int errors;

      function new();
         errors = 0;
         for (int k = 0; k < SensorCount; k++) begin
            current_temp[k] = '0;
            live[k] = 1'b0;
         end
         clear_extremes();
         chars_held = 0;
         for (int k = 0; k < HeadDepth; k++) first_chars[k] = '0;
      endfunction

      function void clear_extremes();
         for (int k = 0; k < SensorCount; k++) begin
            lowest_temp[k] = MinReset;
            highest_temp[k] = MaxReset;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function int pending();
         return expected_replies.size();
      endfunction

      function void take_request(logic cmd, logic [IndexWidth-1:0] idx, logic pres,
                                 logic signed [ValueWidth-1:0] rd, logic [ByteWidth-1:0] rx);
         reply_beat_type beat;
         reply_kind_type kind;
         bit answer;
         logic signed [ValueWidth-1:0] v;
         answer = 1'b0;
         kind = REPLY_OK;
         if (!cmd) begin
            if (idx < SensorCount) begin
               if (!pres) begin
                  live[idx] = 1'b0;
               end else begin
                  live[idx] = 1'b1;
                  current_temp[idx] = rd;
                  if (rd > highest_temp[idx]) highest_temp[idx] = rd;
                  if (rd < lowest_temp[idx]) lowest_temp[idx] = rd;
               end
            end
         end else if (rx == CharCr || rx == CharLf) begin
            if (chars_held >= 2 && first_chars[0] == CharA && first_chars[1] == CharT) begin
               if (chars_held == 2) begin
                  answer = 1'b1;
                  kind = REPLY_OK;
               end else if (chars_held == 4 && first_chars[2] == CharSpace) begin
                  case (first_chars[3])
                     CharR: clear_extremes();
                     CharOne: begin
                        answer = 1'b1;
                        kind = REPLY_CURRENT;
                     end
                     CharTwo: begin
                        answer = 1'b1;
                        kind = REPLY_MIN;
                     end
                     CharThree: begin
                        answer = 1'b1;
                        kind = REPLY_MAX;
                     end
                     CharFour: begin
                        answer = 1'b1;
                        kind = REPLY_ACTIVE;
                     end
                     default: ;
                  endcase
               end
            end
            chars_held = 0;
            if (answer) begin
               beat.kind = kind;
               for (int k = 0; k < 4; k++) begin
                  v = '0;
                  if (k < SensorCount) begin
                     case (kind)
                        REPLY_CURRENT: v = current_temp[k];
                        REPLY_MIN:     v = lowest_temp[k];
                        REPLY_MAX:     v = highest_temp[k];
                        REPLY_ACTIVE:  v = live[k] ? 12'sd1 : 12'sd0;
                        default:       v = '0;
                     endcase
                  end
                  beat.vals[k] = v;
               end
               expected_replies.push_back(beat);
            end
         end else if (chars_held >= LineCapacity) begin
            first_chars[0] = rx;
            chars_held = 1;
         end else begin
            if (chars_held < HeadDepth) first_chars[chars_held] = rx;
            chars_held++;
         end
      endfunction

      task check_reply(logic [2:0] kind, logic [3:0][ValueWidth-1:0] vals);
         reply_beat_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("reply kind %0d with nothing expected", kind));
            return;
         end
         want = expected_replies.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("reply kind %0d, expected %0d", kind, want.kind));
         for (int k = 0; k < 4; k++) begin
            if (vals[k] !== want.vals[k])
               report_mismatch($sformatf("kind %0d value_%0d is %h, expected %h",
                                         want.kind, k, vals[k], want.vals[k]));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [IndexWidth-1:0] req_sensor_index = '0;
   logic req_sensor_present = 1'b0;
   logic signed [ValueWidth-1:0] req_reading = '0;
   logic [ByteWidth-1:0] req_rx_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_reply_kind;
   logic signed [ValueWidth-1:0] rsp_value_0;
   logic signed [ValueWidth-1:0] rsp_value_1;
   logic signed [ValueWidth-1:0] rsp_value_2;
   logic signed [ValueWidth-1:0] rsp_value_3;

   reply_board board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int cycles = 0;

   sensor_minmax_at_command_monitor_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_sensor_index   (req_sensor_index),
      .req_sensor_present (req_sensor_present),
      .req_reading        (req_reading),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_value_0        (rsp_value_0),
      .rsp_value_1        (rsp_value_1),
      .rsp_value_2        (rsp_value_2),
      .rsp_value_3        (rsp_value_3)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_reply(rsp_reply_kind, {rsp_value_3, rsp_value_2, rsp_value_1, rsp_value_0});
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_beat(logic cmd, logic [IndexWidth-1:0] idx, logic pres,
                            logic signed [ValueWidth-1:0] rd, logic [ByteWidth-1:0] rx);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sensor_index <= idx;
      req_sensor_present <= pres;
      req_reading <= rd;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_request(cmd, idx, pres, rd, rx);
      items_sent++;
   endtask

   task automatic send_reading(logic [IndexWidth-1:0] idx, logic pres,
                               logic signed [ValueWidth-1:0] rd);
      send_beat(1'b0, idx, pres, rd, ByteWidth'($urandom));
   endtask

   task automatic send_char(logic [ByteWidth-1:0] c);
      send_beat(1'b1, IndexWidth'($urandom), 1'($urandom), ValueWidth'($urandom), c);
   endtask

   task automatic send_line(string text, bit use_lf);
      for (int i = 0; i < text.len(); i++) send_char(text[i]);
      send_char(use_lf ? CharLf : CharCr);
   endtask

   function automatic logic [ByteWidth-1:0] plain_char();
      logic [ByteWidth-1:0] c;
      c = ByteWidth'($urandom);
      while (c == CharCr || c == CharLf) c = ByteWidth'($urandom);
      return c;
   endfunction

   function automatic logic signed [ValueWidth-1:0] pick_reading();
      case ($urandom_range(9))
         0: return 12'sd2047;
         1: return -12'sd2048;
         2: return 12'sd999;
         3: return -12'sd999;
         4: return 12'sd0;
         default: return ValueWidth'($urandom);
      endcase
   endfunction

   function automatic string pick_command();
      case ($urandom_range(10))
         0, 1: return "AT";
         2, 3: return "AT 1";
         4, 5: return "AT 2";
         6, 7: return "AT 3";
         8, 9: return "AT 4";
         default: return "AT R";
      endcase
   endfunction

   function automatic logic [ByteWidth-1:0] noise_char();
      case ($urandom_range(9))
         0: return CharA;
         1: return CharT;
         2: return CharSpace;
         3: return CharR;
         4: return CharOne;
         5: return 8'h35;
         6: return 8'h00;
         default: return ByteWidth'($urandom);
      endcase
   endfunction

   task automatic random_item();
      string text;
      int pick;
      int pad;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_reading(IndexWidth'($urandom), $urandom_range(9) != 0, pick_reading());
      end else if (pick < 80) begin
         if ($urandom_range(9) == 0) begin
            pad = $urandom_range(LineCapacity, LineCapacity + 4);
            for (int i = 0; i < pad; i++) send_char(plain_char());
         end
         send_line(pick_command(), 1'($urandom));
      end else if (pick < 90) begin
         text = pick_command();
         case ($urandom_range(2))
            0: text = text.substr(0, text.len() - 2);
            1: text = {text, string'(plain_char())};
            default: text[$urandom_range(text.len() - 1)] = plain_char();
         endcase
         send_line(text, 1'($urandom));
      end else begin
         pad = $urandom_range(0, 6);
         for (int i = 0; i < pad; i++) send_char(noise_char());
         if ($urandom_range(9) < 7) send_char($urandom_range(1) ? CharCr : CharLf);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_reading(2'd0, 1'b1, 12'sd2047);
      send_reading(2'd1, 1'b1, -12'sd2048);
      send_reading(2'd2, 1'b1, 12'sd0);
      send_reading(2'd3, 1'b0, 12'sd555);
      send_line("AT 3", 1'b0);
      send_line("AT 2", 1'b1);
      send_line("AT R", 1'b0);
      send_line("AT 4", 1'b0);
      send_line("AT", 1'b1);

      while (items_sent < 200) random_item();
      idle_pct = 78;
      while (items_sent < 400) random_item();
      idle_pct = 0;
      stall_pct = 78;
      while (items_sent < 600) random_item();
      idle_pct = 6;
      stall_pct = 6;
      while (items_sent < 800) random_item();
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
